### src/fts_pkg.sv
`timescale 1ns / 1ps
package fts_pkg;

   localparam int HISTORY_LEN = 8;
   localparam int QUEUE_LEN   = 16;
   localparam int TYPE_COUNT  = 8;

   localparam int HIST_IDX_W  = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam int HIST_CNT_W  = $clog2(HISTORY_LEN + 1);
   localparam int QUEUE_IDX_W = (QUEUE_LEN > 1) ? $clog2(QUEUE_LEN) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_LEN + 1);
   localparam int TYPE_IDX_W  = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
   localparam int HIST_HALF   = HISTORY_LEN / 2;

   localparam logic [47:0] TIME_MASK  = 48'hFFFF_FFFF_FFFF;
   localparam logic [50:0] PROD_LIMIT = 51'h4_0000_0000_0000;

   typedef enum logic [2:0] {
      CMD_EVENT    = 3'd0,
      CMD_SCHEDULE = 3'd1,
      CMD_TICK     = 3'd2,
      CMD_SET      = 3'd3,
      CMD_CLEAR    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_ON_TIME = 2'd0,
      STAT_LATE    = 2'd1,
      STAT_DROPPED = 2'd2
   } status_type;

   typedef enum logic {
      ALU_DIV = 1'b0,
      ALU_MUL = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic        go;
      alu_op_type  op;
      logic [47:0] opa;
      logic [31:0] opb;
   } alu_cmd_type;

endpackage

### src/frame_timed_action_scheduler.sv
`timescale 1ns / 1ps
// Frame-timed action scheduler. An item is accepted on start while busy is
// low; busy then stays high until the item is finished. Results appear as
// one-cycle strobes on rsp_valid and cannot be held off by the receiver;
// rsp_last marks the final result of an item. An exposure event completes
// without raising busy, unless the interval is re-estimated (one quotient bit
// per cycle through the shared divide/multiply unit). A schedule computes the
// deadline with a 32-step multiply in the same unit, then either reports the
// action late or dropped, or inserts it in order by scanning the queue entries
// and then drains the due results. A tick drains the due results. Set delay
// and clear never raise busy.
module frame_timed_action_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [47:0] req_now_time,
   input  logic [31:0] req_frame_number,
   input  logic [47:0] req_event_time,
   input  logic [2:0]  req_action_type,
   input  logic [15:0] req_action_tag,
   input  logic [7:0]  req_frame_delay,
   input  logic [31:0] req_time_delay,
   output logic        rsp_valid,
   output logic [15:0] rsp_run_tag,
   output logic [31:0] rsp_run_frame,
   output logic [2:0]  rsp_run_type,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int HL = fts_pkg::HISTORY_LEN;
   localparam int QL = fts_pkg::QUEUE_LEN;
   localparam int HIW = fts_pkg::HIST_IDX_W;
   localparam int HCW = fts_pkg::HIST_CNT_W;
   localparam int QIW = fts_pkg::QUEUE_IDX_W;
   localparam int QCW = fts_pkg::QUEUE_CNT_W;
   localparam int TIW = fts_pkg::TYPE_IDX_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EV_SUB, ST_EV_WAIT, ST_DL_BASE, ST_DL_MUL, ST_DL_CHECK,
      ST_SCAN, ST_INSERT, ST_DRAIN
   } state_type;

   state_type   state_ff;
   logic [47:0] now_ff;
   logic [31:0] frame_ff;
   logic [2:0]  type_ff;
   logic [15:0] tag_ff;

   logic [47:0]  ring_ff [HL];
   logic [HCW-1:0] ev_count_ff;
   logic [HIW-1:0] ev_head_ff;
   logic [47:0]  last_time_ff;
   logic [31:0]  last_frame_ff;
   logic [47:0]  interval_ff;

   logic         dvalid_ff [fts_pkg::TYPE_COUNT];
   logic [7:0]   dframe_ff [fts_pkg::TYPE_COUNT];
   logic [31:0]  dtime_ff  [fts_pkg::TYPE_COUNT];

   logic [47:0]  q_dl_ff    [QL];
   logic [15:0]  q_tag_ff   [QL];
   logic [31:0]  q_frame_ff [QL];
   logic [2:0]   q_type_ff  [QL];
   logic [QCW-1:0] q_count_ff;
   logic [QCW-1:0] pos_ff;

   logic [53:0]  base_ff;
   logic         neg_ff;
   logic [47:0]  dl_ff;

   fts_pkg::alu_cmd_type alu_cmd_ff;
   logic         alu_done;
   logic [50:0]  alu_result;

   logic        rsp_valid_ff;
   logic [15:0] rsp_tag_ff;
   logic [31:0] rsp_frame_ff;
   logic [2:0]  rsp_type_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_last_ff;

   // combinational helpers
   logic [HCW:0]   slot_sum;
   logic [HIW-1:0] slot;
   logic           ring_full;
   logic [HIW-1:0] head_next;
   logic [HCW-1:0] count_next;
   logic           req_type_hit;
   logic [TIW-1:0] req_type_idx;
   logic           sch_type_hit;
   logic [TIW-1:0] sch_type_idx;
   logic [31:0]    foff;
   logic [53:0]    toff;
   logic [31:0]    lframe;
   logic [47:0]    ltime;
   logic [31:0]    frame_gap;
   logic [31:0]    mag;
   logic [47:0]    oldest;
   logic [53:0]    sprod;
   logic [53:0]    sum;
   logic [47:0]    sum_clamp;
   logic [QCW-1:0] pos_m1;
   logic           q0_due;
   logic           q1_due;

   always_comb begin
      ring_full  = (32'(ev_count_ff) == HL);
      slot_sum   = (HCW+1)'(ev_head_ff) + (HCW+1)'(ev_count_ff);
      if (32'(slot_sum) >= HL) begin
         slot_sum = slot_sum - (HCW+1)'(HL);
      end
      slot       = ring_full ? ev_head_ff : HIW'(slot_sum);
      head_next  = (32'(ev_head_ff) == HL - 1) ? '0 : ev_head_ff + HIW'(1);
      count_next = ring_full ? ev_count_ff : ev_count_ff + HCW'(1);

      req_type_hit = (32'(req_action_type) < fts_pkg::TYPE_COUNT);
      req_type_idx = TIW'(req_action_type);
      sch_type_hit = (32'(type_ff) < fts_pkg::TYPE_COUNT);
      sch_type_idx = TIW'(type_ff);

      if (sch_type_hit && dvalid_ff[sch_type_idx]) begin
         foff = {{24{dframe_ff[sch_type_idx][7]}}, dframe_ff[sch_type_idx]};
         toff = {{22{dtime_ff[sch_type_idx][31]}}, dtime_ff[sch_type_idx]};
      end else begin
         foff = '0;
         toff = '0;
      end
      lframe    = (ev_count_ff != '0) ? last_frame_ff : 32'd0;
      ltime     = (ev_count_ff != '0) ? last_time_ff : now_ff;
      frame_gap = frame_ff - lframe + foff;
      mag       = frame_gap[31] ? (32'd0 - frame_gap) : frame_gap;

      oldest = ring_ff[ev_head_ff];

      sprod  = neg_ff ? (54'd0 - 54'(alu_result)) : 54'(alu_result);
      sum    = base_ff + sprod;
      if (sum[53]) begin
         sum_clamp = '0;
      end else if (sum[52:48] != 5'd0) begin
         sum_clamp = fts_pkg::TIME_MASK;
      end else begin
         sum_clamp = sum[47:0];
      end

      pos_m1 = pos_ff - QCW'(1);
      q0_due = (q_count_ff != '0) && (q_dl_ff[0] <= now_ff);
      q1_due = (32'(q_count_ff) > 1) && (q_dl_ff[1] <= now_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ev_count_ff  <= '0;
         ev_head_ff   <= '0;
         interval_ff  <= '0;
         q_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         alu_cmd_ff.go <= 1'b0;
         for (int i = 0; i < fts_pkg::TYPE_COUNT; i++) begin
            dvalid_ff[i] <= 1'b0;
         end
      end else begin
         rsp_valid_ff  <= 1'b0;
         alu_cmd_ff.go <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  now_ff   <= req_now_time;
                  frame_ff <= req_frame_number;
                  type_ff  <= req_action_type;
                  tag_ff   <= req_action_tag;
                  case (req_cmd)
                     fts_pkg::CMD_EVENT: begin
                        ring_ff[slot] <= req_event_time;
                        last_time_ff  <= req_event_time;
                        last_frame_ff <= req_frame_number;
                        ev_count_ff   <= count_next;
                        if (ring_full) begin
                           ev_head_ff <= head_next;
                        end
                        if (32'(count_next) > fts_pkg::HIST_HALF && 32'(count_next) >= 2) begin
                           state_ff <= ST_EV_SUB;
                        end
                     end
                     fts_pkg::CMD_SCHEDULE: state_ff <= ST_DL_BASE;
                     fts_pkg::CMD_TICK:     state_ff <= ST_DRAIN;
                     fts_pkg::CMD_SET: begin
                        if (req_type_hit) begin
                           dvalid_ff[req_type_idx] <= 1'b1;
                           dframe_ff[req_type_idx] <= req_frame_delay;
                           dtime_ff[req_type_idx]  <= req_time_delay;
                        end
                     end
                     fts_pkg::CMD_CLEAR: begin
                        ev_count_ff <= '0;
                        ev_head_ff  <= '0;
                        q_count_ff  <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_EV_SUB: begin
               if (last_time_ff < oldest) begin
                  interval_ff <= '0;
                  state_ff    <= ST_IDLE;
               end else begin
                  alu_cmd_ff.go  <= 1'b1;
                  alu_cmd_ff.op  <= fts_pkg::ALU_DIV;
                  alu_cmd_ff.opa <= last_time_ff - oldest;
                  alu_cmd_ff.opb <= 32'(ev_count_ff) - 32'd1;
                  state_ff       <= ST_EV_WAIT;
               end
            end
            ST_EV_WAIT: begin
               if (alu_done) begin
                  interval_ff <= alu_result[47:0];
                  state_ff    <= ST_IDLE;
               end
            end
            ST_DL_BASE: begin
               neg_ff         <= frame_gap[31];
               base_ff        <= 54'(ltime) + toff;
               alu_cmd_ff.go  <= 1'b1;
               alu_cmd_ff.op  <= fts_pkg::ALU_MUL;
               alu_cmd_ff.opa <= interval_ff;
               alu_cmd_ff.opb <= mag;
               state_ff       <= ST_DL_MUL;
            end
            ST_DL_MUL: begin
               if (alu_done) begin
                  dl_ff    <= sum_clamp;
                  state_ff <= ST_DL_CHECK;
               end
            end
            ST_DL_CHECK: begin
               if (dl_ff < now_ff || 32'(q_count_ff) >= QL) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_tag_ff    <= tag_ff;
                  rsp_frame_ff  <= frame_ff;
                  rsp_type_ff   <= type_ff;
                  rsp_status_ff <= (dl_ff < now_ff) ? fts_pkg::STAT_LATE
                                                    : fts_pkg::STAT_DROPPED;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  pos_ff   <= q_count_ff;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (pos_ff == '0 || !(q_dl_ff[QIW'(pos_m1)] > dl_ff)) begin
                  state_ff <= ST_INSERT;
               end else begin
                  pos_ff <= pos_m1;
               end
            end
            ST_INSERT: begin
               for (int i = 0; i < QL; i++) begin
                  if (i == 32'(pos_ff)) begin
                     q_dl_ff[i]    <= dl_ff;
                     q_tag_ff[i]   <= tag_ff;
                     q_frame_ff[i] <= frame_ff;
                     q_type_ff[i]  <= type_ff;
                  end else if (i > 32'(pos_ff) && i <= 32'(q_count_ff) && i > 0) begin
                     q_dl_ff[i]    <= q_dl_ff[i-1];
                     q_tag_ff[i]   <= q_tag_ff[i-1];
                     q_frame_ff[i] <= q_frame_ff[i-1];
                     q_type_ff[i]  <= q_type_ff[i-1];
                  end
               end
               q_count_ff <= q_count_ff + QCW'(1);
               state_ff   <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (q0_due) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_tag_ff    <= q_tag_ff[0];
                  rsp_frame_ff  <= q_frame_ff[0];
                  rsp_type_ff   <= q_type_ff[0];
                  rsp_status_ff <= fts_pkg::STAT_ON_TIME;
                  rsp_last_ff   <= !q1_due;
                  for (int i = 0; i < QL - 1; i++) begin
                     q_dl_ff[i]    <= q_dl_ff[i+1];
                     q_tag_ff[i]   <= q_tag_ff[i+1];
                     q_frame_ff[i] <= q_frame_ff[i+1];
                     q_type_ff[i]  <= q_type_ff[i+1];
                  end
                  q_count_ff <= q_count_ff - QCW'(1);
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   fts_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_tag   = rsp_tag_ff;
   assign rsp_run_frame = rsp_frame_ff;
   assign rsp_run_type  = rsp_type_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(q_count_ff) <= QL)
      else $error("queue count exceeds depth");

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      32'(ev_count_ff) <= HL)
      else $error("event count exceeds depth");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result transfer after final result");

   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |=> q_count_ff == $past(q_count_ff) + QCW'(1))
      else $error("insert did not grow queue");
`endif

endmodule

### src/fts_alu.sv
`timescale 1ns / 1ps
module fts_alu (
   input  logic                clock,
   input  logic                reset,
   input  fts_pkg::alu_cmd_type cmd,
   output logic                done,
   output logic [50:0]         result
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   fts_pkg::alu_op_type op_ff, op_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [47:0]         sh_ff, sh_in;
   logic [32:0]         rem_ff, rem_in;
   logic [51:0]         acc_ff, acc_in;
   logic                ovf_ff, ovf_in;
   logic [47:0]         a_ff, a_in;
   logic [31:0]         b_ff, b_in;

   logic [32:0] trial;
   logic [51:0] nx;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      trial   = {rem_ff[31:0], sh_ff[47]};
      nx      = {acc_ff[50:0], 1'b0} + (sh_ff[47] ? {4'd0, a_ff} : 52'd0);
      if (cmd.go && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         if (cmd.op == fts_pkg::ALU_DIV) begin
            sh_in  = cmd.opa;
            b_in   = cmd.opb;
            rem_in = '0;
            cnt_in = 6'd47;
         end else begin
            sh_in  = {cmd.opb, 16'd0};
            a_in   = cmd.opa;
            acc_in = '0;
            ovf_in = 1'b0;
            cnt_in = 6'd31;
         end
      end else if (busy_ff) begin
         if (op_ff == fts_pkg::ALU_DIV) begin
            if (trial >= {1'b0, b_ff}) begin
               rem_in = trial - {1'b0, b_ff};
               sh_in  = {sh_ff[46:0], 1'b1};
            end else begin
               rem_in = trial;
               sh_in  = {sh_ff[46:0], 1'b0};
            end
         end else begin
            sh_in = {sh_ff[46:0], 1'b0};
            if (!ovf_ff) begin
               if (nx > {1'b0, fts_pkg::PROD_LIMIT}) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = nx;
               end
            end
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == fts_pkg::ALU_DIV) ? {3'd0, sh_ff}
                 : (ovf_ff ? fts_pkg::PROD_LIMIT : acc_ff[50:0]);

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [47:0] now_time;
      logic [31:0] frame_number;
      logic [47:0] event_time;
      logic [2:0]  action_type;
      logic [15:0] action_tag;
      logic [7:0]  frame_delay;
      logic [31:0] time_delay;
   } request_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [31:0] frame;
      logic [2:0]  atype;
      logic [1:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [47:0] deadline;
      logic [15:0] tag;
      logic [31:0] frame;
      logic [2:0]  atype;
   } entry_type;

   localparam logic [2:0] CMD_BAD = 3'd7;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_cmd = '0;
   logic [47:0] req_now_time = '0;
   logic [31:0] req_frame_number = '0;
   logic [47:0] req_event_time = '0;
   logic [2:0]  req_action_type = '0;
   logic [15:0] req_action_tag = '0;
   logic [7:0]  req_frame_delay = '0;
   logic [31:0] req_time_delay = '0;
   logic        rsp_valid;
   logic [15:0] rsp_run_tag;
   logic [31:0] rsp_run_frame;
   logic [2:0]  rsp_run_type;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   frame_timed_action_scheduler DUT (.*);

   always #10 clock = ~clock;

   // scheduler state mirror
   logic [31:0] ev_frame [fts_pkg::HISTORY_LEN];
   logic [47:0] ev_time [fts_pkg::HISTORY_LEN];
   int          ev_count, ev_head;
   logic [47:0] interval;
   logic        dly_valid [fts_pkg::TYPE_COUNT];
   logic [7:0]  dly_frame [fts_pkg::TYPE_COUNT];
   logic [31:0] dly_time [fts_pkg::TYPE_COUNT];
   entry_type   pending_actions [$];

   request_type send_queue [$];
   result_type  expected_runs [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          quiet_cycles = 0;
   bit          hold_until_empty = 0;
   bit          no_gaps = 0;
   bit          stimulus_done = 0;

   function automatic void push_run(entry_type s, fts_pkg::status_type st);
      result_type r;
      r.tag = s.tag; r.frame = s.frame; r.atype = s.atype;
      r.status = st; r.last = 1'b0;
      expected_runs = {expected_runs, r};
   endfunction

   function automatic void drain_due_actions(logic [47:0] now);
      while (pending_actions.size() > 0 && pending_actions[0].deadline <= now) begin
         push_run(pending_actions[0], fts_pkg::STAT_ON_TIME);
         pending_actions.delete(0);
      end
   endfunction

   function automatic logic [47:0] action_deadline(logic [31:0] frame, logic [2:0] atype,
                                                   logic [47:0] now);
      logic [31:0] last_frame, gap_u, foff;
      logic [47:0] last_time;
      longint      toff, frame_gap, prod, total;
      logic [63:0] mag;
      int          newest;
      last_frame = '0; last_time = now; foff = '0; toff = 0;
      if (ev_count > 0) begin
         newest = (ev_head + ev_count - 1) % fts_pkg::HISTORY_LEN;
         last_frame = ev_frame[newest];
         last_time = ev_time[newest];
      end
      if (dly_valid[atype]) begin
         foff = {{24{dly_frame[atype][7]}}, dly_frame[atype]};
         toff = longint'(signed'(dly_time[atype]));
      end
      gap_u = frame - last_frame + foff;
      frame_gap = longint'(signed'(gap_u));
      mag = (frame_gap < 0) ? 64'(-frame_gap) : 64'(frame_gap);
      if (interval != '0 && mag > (64'd1 << 50) / 64'(interval))
         prod = longint'(1) << 50;
      else
         prod = longint'(mag * 64'(interval));
      if (frame_gap < 0) prod = -prod;
      total = longint'(last_time) + prod + toff;
      if (total < 0) return '0;
      if (total > longint'(fts_pkg::TIME_MASK)) return fts_pkg::TIME_MASK;
      return total[47:0];
   endfunction

   function automatic void predict_request(request_type q);
      int n0, slot, newest;
      entry_type s;
      logic [47:0] dl;
      n0 = expected_runs.size();
      case (q.cmd)
         fts_pkg::CMD_EVENT: begin
            if (ev_count < fts_pkg::HISTORY_LEN) begin
               slot = (ev_head + ev_count) % fts_pkg::HISTORY_LEN;
               ev_count++;
            end else begin
               slot = ev_head;
               ev_head = (ev_head + 1) % fts_pkg::HISTORY_LEN;
            end
            ev_frame[slot] = q.frame_number;
            ev_time[slot] = q.event_time;
            if (ev_count > fts_pkg::HIST_HALF && ev_count >= 2) begin
               newest = (ev_head + ev_count - 1) % fts_pkg::HISTORY_LEN;
               if (ev_time[newest] < ev_time[ev_head]) interval = '0;
               else interval = (ev_time[newest] - ev_time[ev_head]) / 48'(ev_count - 1);
            end
         end
         fts_pkg::CMD_SCHEDULE: begin
            dl = action_deadline(q.frame_number, q.action_type, q.now_time);
            s.deadline = dl; s.tag = q.action_tag;
            s.frame = q.frame_number; s.atype = q.action_type;
            if (dl < q.now_time) push_run(s, fts_pkg::STAT_LATE);
            else if (pending_actions.size() >= fts_pkg::QUEUE_LEN)
               push_run(s, fts_pkg::STAT_DROPPED);
            else begin
               slot = pending_actions.size();
               while (slot > 0 && pending_actions[slot - 1].deadline > dl) slot--;
               pending_actions.insert(slot, s);
               drain_due_actions(q.now_time);
            end
         end
         fts_pkg::CMD_TICK: drain_due_actions(q.now_time);
         fts_pkg::CMD_SET: begin
            dly_valid[q.action_type] = 1'b1;
            dly_frame[q.action_type] = q.frame_delay;
            dly_time[q.action_type] = q.time_delay;
         end
         fts_pkg::CMD_CLEAR: begin
            ev_count = 0; ev_head = 0;
            pending_actions.delete();
         end
         default: ;
      endcase
      if (expected_runs.size() > n0) expected_runs[expected_runs.size() - 1].last = 1'b1;
   endfunction

   // driver
   always @(posedge clock) begin
      request_type q;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) predict_request({req_cmd, req_now_time, req_frame_number, req_event_time,
                                     req_action_type, req_action_tag, req_frame_delay,
                                     req_time_delay});
         if (send_queue.size() > 0 && !(hold_until_empty && (start || busy
               || expected_runs.size() > 0)) && (no_gaps || $urandom_range(99) >= 22)) begin
            q = send_queue[0];
            send_queue.delete(0);
            if (q.cmd == fts_pkg::CMD_SCHEDULE) hold_until_empty = 0;
            {req_cmd, req_now_time, req_frame_number, req_event_time, req_action_type,
             req_action_tag, req_frame_delay, req_time_delay} <= q;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         result_type got, want;
         got = {rsp_run_tag, rsp_run_frame, rsp_run_type, rsp_status, rsp_last};
         if (expected_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = expected_runs[0];
            expected_runs.delete(0);
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected tag %h frame %h type %0d status %0d",
                            " last %0b, got tag %h frame %h type %0d status %0d last %0b"},
                           want.tag, want.frame, want.atype, want.status, want.last,
                           got.tag, got.frame, got.atype, got.status, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic request_type make_request(logic [2:0] cmd, logic [47:0] now,
                                                logic [31:0] frame, logic [47:0] et,
                                                logic [2:0] atype);
      request_type q;
      q.cmd = cmd; q.now_time = now; q.frame_number = frame; q.event_time = et;
      q.action_type = atype; q.action_tag = 16'($urandom);
      q.frame_delay = 8'($urandom); q.time_delay = $urandom;
      return q;
   endfunction

   function automatic void add_stream(int n);
      logic [47:0] base, period;
      logic [31:0] frame;
      request_type q;
      int pick;
      base = {16'($urandom_range(1000)), 32'($urandom)};
      period = 48'($urandom_range(1000, 40_000_000));
      frame = $urandom;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            frame++;
            base = base + period + 48'($urandom_range(2000)) - 48'd1000;
            q = make_request(fts_pkg::CMD_EVENT, base, frame, base, 3'($urandom));
         end else if (pick < 65) begin
            q = make_request(fts_pkg::CMD_SCHEDULE, base + 48'($urandom_range(3)) * period,
                             frame + $urandom_range(6) - 32'd1, '0, 3'($urandom));
         end else if (pick < 78) begin
            q = make_request(fts_pkg::CMD_TICK, base + 48'($urandom_range(8)) * period,
                             '0, '0, 3'($urandom));
         end else if (pick < 86) begin
            q = make_request(fts_pkg::CMD_SET, '0, '0, '0, 3'($urandom));
            q.frame_delay = 8'($urandom_range(4)) - 8'd2;
            q.time_delay = $urandom_range(32'(2 * period)) - 32'(period);
         end else if (pick < 89) begin
            q = make_request(fts_pkg::CMD_CLEAR, '0, '0, '0, '0);
         end else begin
            q = make_request(3'($urandom_range(7)), {16'($urandom), 32'($urandom)}, $urandom,
                             {16'($urandom), 32'($urandom)}, 3'($urandom));
         end
         send_queue = {send_queue, q};
      end
   endfunction

   initial begin
      request_type q;
      logic [47:0] tmax;
      tmax = fts_pkg::TIME_MASK;
      for (int i = 0; i < fts_pkg::TYPE_COUNT; i++) dly_valid[i] = 1'b0;
      ev_count = 0; ev_head = 0; interval = '0;

      // directed: empty ring, extremes, saturations, late, full queue, ties
      send_queue = {send_queue, make_request(fts_pkg::CMD_SCHEDULE, '0, '0, '0, 3'd0)};
      send_queue = {send_queue,
                    make_request(fts_pkg::CMD_SCHEDULE, tmax, 32'hFFFF_FFFF, '0, 3'd7)};
      q = make_request(fts_pkg::CMD_SET, '0, '0, '0, 3'd1);
      q.frame_delay = 8'h80; q.time_delay = 32'h8000_0000;
      send_queue = {send_queue, q};
      send_queue = {send_queue, make_request(fts_pkg::CMD_SCHEDULE, 48'd100, 32'd5, '0, 3'd1)};
      q = make_request(fts_pkg::CMD_SET, '0, '0, '0, 3'd2);
      q.frame_delay = 8'h7F; q.time_delay = 32'h7FFF_FFFF;
      send_queue = {send_queue, q};
      for (int i = 0; i < 6; i++)
         send_queue = {send_queue, make_request(fts_pkg::CMD_EVENT, '0, 32'(i),
                                                48'(i) * 48'd1000, '0)};
      send_queue = {send_queue, make_request(fts_pkg::CMD_EVENT, '0, 32'd6, 48'd10, '0)};
      send_queue = {send_queue, make_request(fts_pkg::CMD_EVENT, '0, 32'hFFFF_FFFF, tmax, '0)};
      send_queue = {send_queue, make_request(fts_pkg::CMD_EVENT, '0, 32'h8000_0000, tmax, '0)};
      send_queue = {send_queue, make_request(fts_pkg::CMD_SCHEDULE, 48'd0, 32'h0, '0, 3'd2)};
      send_queue = {send_queue, make_request(fts_pkg::CMD_SCHEDULE, tmax, 32'h0, '0, 3'd0)};
      for (int i = 0; i < 18; i++)
         send_queue = {send_queue, make_request(fts_pkg::CMD_SCHEDULE, 48'd5, 32'h8000_0000,
                                                '0, 3'd0)};
      send_queue = {send_queue, make_request(fts_pkg::CMD_TICK, tmax, '0, '0, '0)};
      send_queue = {send_queue, make_request(fts_pkg::CMD_CLEAR, '0, '0, '0, '0)};
      send_queue = {send_queue, make_request(CMD_BAD, '1, '1, '1, '1)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_stream(180);
      wait (send_queue.size() == 0);
      no_gaps = 1;
      add_stream(80);
      wait (send_queue.size() == 0);
      @(posedge clock);
      no_gaps = 0;
      hold_until_empty = 1;
      add_stream(180);
      wait (send_queue.size() == 0);
      stimulus_done = 1;
   end

   always @(posedge clock) begin
      if (stimulus_done && !start && !busy && expected_runs.size() == 0) begin
         quiet_cycles++;
         if (quiet_cycles > 200) begin
            if (mismatches == 0) $display("tb_top: PASS");
            else $display("tb_top: FAIL");
            $finish;
         end
      end else begin
         quiet_cycles = 0;
      end
   end
endmodule
